// ===== src/rvex_pkg.sv =====
`default_nettype none

package rvex_pkg;

    // widths of the data path and of the register numbers
    localparam int XLEN      = 32;
    localparam int REG_IDX_W = 5;
    localparam int FUNC_W    = 6;

    // default register count, handed to the top level as a parameter
    localparam int NUM_REGS_DEFAULT = 32;

    // pc step for one instruction
    localparam logic [XLEN-1:0] INSN_BYTES = 32'd4;

    // input word layout, lowest bit first
    localparam int S_FUNC_LSB  = 0;
    localparam int S_RD_LSB    = 6;
    localparam int S_RS1_LSB   = 11;
    localparam int S_RS2_LSB   = 16;
    localparam int S_IMM_LSB   = 21;
    localparam int S_RDATA_LSB = 53;
    localparam int S_OK_BIT    = 85;
    localparam int S_TDATA_W   = 88;

    // output word width (141 payload bits padded to whole bytes)
    localparam int M_PAYLOAD_W = 141;
    localparam int M_TDATA_W   = 144;

    // kind of an input word
    localparam logic KIND_INSN = 1'b0;
    localparam logic KIND_RESP = 1'b1;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 6'd0;
    localparam logic [FUNC_W-1:0] FUNC_AND   = 6'd9;
    localparam logic [FUNC_W-1:0] FUNC_ADDI  = 6'd10;
    localparam logic [FUNC_W-1:0] FUNC_SLTI  = 6'd11;
    localparam logic [FUNC_W-1:0] FUNC_SLTIU = 6'd12;
    localparam logic [FUNC_W-1:0] FUNC_XORI  = 6'd13;
    localparam logic [FUNC_W-1:0] FUNC_ORI   = 6'd14;
    localparam logic [FUNC_W-1:0] FUNC_ANDI  = 6'd15;
    localparam logic [FUNC_W-1:0] FUNC_SB    = 6'd16;
    localparam logic [FUNC_W-1:0] FUNC_SH    = 6'd17;
    localparam logic [FUNC_W-1:0] FUNC_SW    = 6'd18;
    localparam logic [FUNC_W-1:0] FUNC_LB    = 6'd19;
    localparam logic [FUNC_W-1:0] FUNC_LH    = 6'd20;
    localparam logic [FUNC_W-1:0] FUNC_LW    = 6'd21;
    localparam logic [FUNC_W-1:0] FUNC_LBU   = 6'd22;
    localparam logic [FUNC_W-1:0] FUNC_LHU   = 6'd23;
    localparam logic [FUNC_W-1:0] FUNC_BEQ   = 6'd24;
    localparam logic [FUNC_W-1:0] FUNC_BNE   = 6'd25;
    localparam logic [FUNC_W-1:0] FUNC_BLT   = 6'd26;
    localparam logic [FUNC_W-1:0] FUNC_BGE   = 6'd27;
    localparam logic [FUNC_W-1:0] FUNC_BLTU  = 6'd28;
    localparam logic [FUNC_W-1:0] FUNC_BGEU  = 6'd29;
    localparam logic [FUNC_W-1:0] FUNC_JALR  = 6'd30;
    localparam logic [FUNC_W-1:0] FUNC_JAL   = 6'd31;
    localparam logic [FUNC_W-1:0] FUNC_LUI   = 6'd32;
    localparam logic [FUNC_W-1:0] FUNC_AUIPC = 6'd33;
    localparam logic [FUNC_W-1:0] FUNC_ECALL = 6'd34;

    // alu operations, same numbering as the register-register forms
    typedef enum logic [3:0] {
        ALU_ADD  = 4'd0,
        ALU_SUB  = 4'd1,
        ALU_SLL  = 4'd2,
        ALU_SLT  = 4'd3,
        ALU_SLTU = 4'd4,
        ALU_XOR  = 4'd5,
        ALU_SRL  = 4'd6,
        ALU_SRA  = 4'd7,
        ALU_OR   = 4'd8,
        ALU_AND  = 4'd9
    } alu_op_t;

    typedef enum logic [1:0] {
        STAT_RUN      = 2'd0,
        STAT_MEM_VIOL = 2'd1,
        STAT_ECALL    = 2'd2
    } run_status_t;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2
    } mem_size_t;

    typedef struct packed {
        logic [XLEN-1:0]      wb_value;
        logic [REG_IDX_W-1:0] wb_reg;
        logic                 wb_valid;
        logic [XLEN-1:0]      mem_write_data;
        logic [XLEN-1:0]      mem_address;
        mem_size_t            mem_size;
        logic                 mem_write;
        logic                 mem_request;
        run_status_t          run_status;
        logic [XLEN-1:0]      next_pc;
        logic                 retired;
    } result_t;

    function automatic logic [XLEN-1:0] alu(alu_op_t op, logic [XLEN-1:0] a,
                                            logic [XLEN-1:0] b);
        logic [XLEN-1:0] r;
        unique case (op)
            ALU_ADD:  r = a + b;
            ALU_SUB:  r = a - b;
            ALU_SLL:  r = a << b[4:0];
            ALU_SLT:  r = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
            ALU_SLTU: r = {{(XLEN-1){1'b0}}, (a < b)};
            ALU_XOR:  r = a ^ b;
            ALU_SRL:  r = a >> b[4:0];
            ALU_SRA:  r = $unsigned($signed(a) >>> b[4:0]);
            ALU_OR:   r = a | b;
            default:  r = a & b;
        endcase
        return r;
    endfunction

    function automatic alu_op_t imm_alu_op(logic [FUNC_W-1:0] func);
        alu_op_t op;
        unique case (func)
            FUNC_ADDI:  op = ALU_ADD;
            FUNC_SLTI:  op = ALU_SLT;
            FUNC_SLTIU: op = ALU_SLTU;
            FUNC_XORI:  op = ALU_XOR;
            FUNC_ORI:   op = ALU_OR;
            default:    op = ALU_AND;
        endcase
        return op;
    endfunction

    function automatic mem_size_t access_size(logic [FUNC_W-1:0] func);
        mem_size_t s;
        unique case (func)
            FUNC_SB, FUNC_LB, FUNC_LBU: s = SIZE_BYTE;
            FUNC_SH, FUNC_LH, FUNC_LHU: s = SIZE_HALF;
            default:                    s = SIZE_WORD;
        endcase
        return s;
    endfunction

    function automatic logic is_load(logic [FUNC_W-1:0] func);
        return (func >= FUNC_LB) && (func <= FUNC_LHU);
    endfunction

    function automatic logic [XLEN-1:0] load_extend(logic [FUNC_W-1:0] func,
                                                    logic [XLEN-1:0] d);
        logic [XLEN-1:0] v;
        unique case (func)
            FUNC_LB:  v = {{(XLEN-8){d[7]}}, d[7:0]};
            FUNC_LH:  v = {{(XLEN-16){d[15]}}, d[15:0]};
            FUNC_LBU: v = {{(XLEN-8){1'b0}}, d[7:0]};
            FUNC_LHU: v = {{(XLEN-16){1'b0}}, d[15:0]};
            default:  v = d;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/rv32i_execute_unit.sv =====
`default_nettype none

// channel   | dir | signals                        | contents
// ----------+-----+--------------------------------+-------------------------------------
// input     | in  | s_tvalid s_tready s_tdata s_tuser | decoded instruction or memory response
// result    | out | m_tvalid m_tready m_tdata      | retire, pc, status, access, write-back
// config    | in  | cfg_we cfg_wdata               | start address, loads pc at once
//
// one word per cycle unless the output stalls; from s_tvalid to m_tvalid a word passes
// an input stage that also reads both operands from the register file rams,
// then the execute logic into the output register
// reset clears pc to zero, status, pending access and the register valid bits
// (registers never written read as zero); ram contents need no clearing
// a stalled output holds the result and the input stage; a load or store waits
// for a response word, which is just the next input word of kind response

module rv32i_execute_unit #(
    parameter int NUM_REGS = rvex_pkg::NUM_REGS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // start address register
    input  logic                           cfg_we,
    input  logic [rvex_pkg::XLEN-1:0]      cfg_wdata,
    // input words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // func[5:0] dest_reg[10:6] src1_reg[15:11] src2_reg[20:16] imm_value[52:21]
    // mem_read_data[84:53] mem_ok[85] zero[87:86]
    input  logic [rvex_pkg::S_TDATA_W-1:0] s_tdata,
    // item_kind[0]
    input  logic [0:0]                     s_tuser,
    // result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // retired[0] next_pc[32:1] run_status[34:33] mem_request[35] mem_write[36]
    // mem_size[38:37] mem_address[70:39] mem_write_data[102:71] wb_valid[103]
    // wb_reg[108:104] wb_value[140:109] zero[143:141]
    output logic [rvex_pkg::M_TDATA_W-1:0] m_tdata
);

    import rvex_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    // input word fields
    logic [FUNC_W-1:0]    s_func;
    logic [REG_IDX_W-1:0] s_rd;
    logic [REG_IDX_W-1:0] s_rs1;
    logic [REG_IDX_W-1:0] s_rs2;
    logic [XLEN-1:0]      s_imm;
    logic [XLEN-1:0]      s_rdata;
    logic                 s_ok;

    assign s_func  = s_tdata[S_FUNC_LSB +: FUNC_W];
    assign s_rd    = s_tdata[S_RD_LSB +: REG_IDX_W];
    assign s_rs1   = s_tdata[S_RS1_LSB +: REG_IDX_W];
    assign s_rs2   = s_tdata[S_RS2_LSB +: REG_IDX_W];
    assign s_imm   = s_tdata[S_IMM_LSB +: XLEN];
    assign s_rdata = s_tdata[S_RDATA_LSB +: XLEN];
    assign s_ok    = s_tdata[S_OK_BIT];

    // handshake
    logic in_valid_reg;
    logic out_valid_reg;
    logic accept;
    logic fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    // architectural state
    logic [XLEN-1:0]      pc_reg;
    logic [XLEN-1:0]      pc_next;
    run_status_t          halt_reg;
    run_status_t          halt_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic [REG_IDX_W-1:0] pend_rd_reg;
    logic [REG_IDX_W-1:0] pend_rd_next;
    logic [FUNC_W-1:0]    pend_func_reg;
    logic [FUNC_W-1:0]    pend_func_next;
    logic [NUM_REGS-1:0]  reg_vld_reg;

    // register file write port
    logic                 wb_we;
    logic [REG_IDX_W-1:0] wb_idx;
    logic [XLEN-1:0]      wb_val;

    // input stage
    logic                 in_kind_reg;
    logic [FUNC_W-1:0]    in_func_reg;
    logic [REG_IDX_W-1:0] in_rd_reg;
    logic [XLEN-1:0]      in_imm_reg;
    logic [XLEN-1:0]      in_rdata_reg;
    logic                 in_ok_reg;
    logic                 rs1_live_reg;
    logic                 rs2_live_reg;
    logic                 rs1_fwd_reg;
    logic                 rs2_fwd_reg;
    logic [XLEN-1:0]      fwd_val_reg;

    // a source is live when it names a written, in-range, nonzero register
    logic                 rs1_in_range;
    logic                 rs2_in_range;
    logic                 rs1_fwd_next;
    logic                 rs2_fwd_next;
    logic                 rs1_live_next;
    logic                 rs2_live_next;

    assign rs1_in_range  = (s_rs1 != '0) && ({1'b0, s_rs1} < (REG_IDX_W+1)'(NUM_REGS));
    assign rs2_in_range  = (s_rs2 != '0) && ({1'b0, s_rs2} < (REG_IDX_W+1)'(NUM_REGS));
    // the word now leaving the input stage may write a source of the new word
    assign rs1_fwd_next  = wb_we && (wb_idx == s_rs1);
    assign rs2_fwd_next  = wb_we && (wb_idx == s_rs2);
    assign rs1_live_next = rs1_in_range && (reg_vld_reg[s_rs1[AW-1:0]] || rs1_fwd_next);
    assign rs2_live_next = rs2_in_range && (reg_vld_reg[s_rs2[AW-1:0]] || rs2_fwd_next);

    // two copies of the register file, one per read port
    logic [XLEN-1:0] ram1_rdata;
    logic [XLEN-1:0] ram2_rdata;

    rvex_ram #(
        .WIDTH (XLEN),
        .DEPTH (NUM_REGS)
    ) u_rf_a (
        .clk   (clk),
        .we    (wb_we),
        .waddr (wb_idx[AW-1:0]),
        .wdata (wb_val),
        .re    (accept),
        .raddr (s_rs1[AW-1:0]),
        .rdata (ram1_rdata)
    );

    rvex_ram #(
        .WIDTH (XLEN),
        .DEPTH (NUM_REGS)
    ) u_rf_b (
        .clk   (clk),
        .we    (wb_we),
        .waddr (wb_idx[AW-1:0]),
        .wdata (wb_val),
        .re    (accept),
        .raddr (s_rs2[AW-1:0]),
        .rdata (ram2_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_kind_reg  <= s_tuser[0];
            in_func_reg  <= s_func;
            in_rd_reg    <= s_rd;
            in_imm_reg   <= s_imm;
            in_rdata_reg <= s_rdata;
            in_ok_reg    <= s_ok;
            rs1_live_reg <= rs1_live_next;
            rs2_live_reg <= rs2_live_next;
            rs1_fwd_reg  <= rs1_fwd_next;
            rs2_fwd_reg  <= rs2_fwd_next;
            fwd_val_reg  <= wb_val;
        end
    end

    // operands
    logic [XLEN-1:0] op_a;
    logic [XLEN-1:0] op_b;

    assign op_a = !rs1_live_reg ? '0 : (rs1_fwd_reg ? fwd_val_reg : ram1_rdata);
    assign op_b = !rs2_live_reg ? '0 : (rs2_fwd_reg ? fwd_val_reg : ram2_rdata);

    // execute
    logic [XLEN-1:0] npc;
    logic [XLEN-1:0] sum_a_imm;
    logic [XLEN-1:0] sum_pc_imm;
    logic            taken;
    logic            wr_req;
    logic [XLEN-1:0] wr_val;
    logic [REG_IDX_W-1:0] wr_idx;
    result_t         res;

    assign npc        = pc_reg + INSN_BYTES;
    assign sum_a_imm  = op_a + in_imm_reg;
    assign sum_pc_imm = pc_reg + in_imm_reg;

    always_comb
    begin
        unique case (in_func_reg)
            FUNC_BEQ:  taken = (op_a == op_b);
            FUNC_BNE:  taken = (op_a != op_b);
            FUNC_BLT:  taken = ($signed(op_a) < $signed(op_b));
            FUNC_BGE:  taken = !($signed(op_a) < $signed(op_b));
            FUNC_BLTU: taken = (op_a < op_b);
            default:   taken = (op_a >= op_b);
        endcase
    end

    always_comb
    begin
        res            = '0;
        pc_next        = pc_reg;
        halt_next      = halt_reg;
        pend_next      = pend_reg;
        pend_rd_next   = pend_rd_reg;
        pend_func_next = pend_func_reg;
        wr_req         = 1'b0;
        wr_idx         = in_rd_reg;
        wr_val         = '0;

        if (halt_reg != STAT_RUN)
        begin
            // halted: everything is dropped until reset
        end
        else if (in_kind_reg == KIND_RESP)
        begin
            if (pend_reg)
            begin
                pend_next      = 1'b0;
                pend_rd_next   = '0;
                pend_func_next = '0;
                if (!in_ok_reg)
                begin
                    halt_next = STAT_MEM_VIOL;
                end
                else
                begin
                    if (is_load(pend_func_reg))
                    begin
                        wr_req = 1'b1;
                        wr_idx = pend_rd_reg;
                        wr_val = load_extend(pend_func_reg, in_rdata_reg);
                    end
                    pc_next     = npc;
                    res.retired = 1'b1;
                end
            end
        end
        else if (!pend_reg)
        begin
            res.retired = 1'b1;
            priority if (in_func_reg <= FUNC_AND)
            begin
                wr_req  = 1'b1;
                wr_val  = alu(alu_op_t'(in_func_reg[3:0]), op_a, op_b);
                pc_next = npc;
            end
            else if (in_func_reg <= FUNC_ANDI)
            begin
                wr_req  = 1'b1;
                wr_val  = alu(imm_alu_op(in_func_reg), op_a, in_imm_reg);
                pc_next = npc;
            end
            else if (in_func_reg <= FUNC_LHU)
            begin
                // load or store leaves as a request, finishes on the response
                res.retired     = 1'b0;
                res.mem_request = 1'b1;
                res.mem_write   = (in_func_reg <= FUNC_SW);
                res.mem_size    = access_size(in_func_reg);
                res.mem_address = sum_a_imm;
                res.mem_write_data = (in_func_reg <= FUNC_SW) ? op_b : '0;
                pend_next       = 1'b1;
                pend_rd_next    = in_rd_reg;
                pend_func_next  = in_func_reg;
            end
            else if (in_func_reg <= FUNC_BGEU)
            begin
                pc_next = taken ? sum_pc_imm : npc;
            end
            else if (in_func_reg == FUNC_JALR)
            begin
                wr_req  = 1'b1;
                wr_val  = npc;
                pc_next = {sum_a_imm[XLEN-1:1], 1'b0};
            end
            else if (in_func_reg == FUNC_JAL)
            begin
                wr_req  = 1'b1;
                wr_val  = npc;
                pc_next = sum_pc_imm;
            end
            else if (in_func_reg == FUNC_LUI)
            begin
                wr_req  = 1'b1;
                wr_val  = in_imm_reg;
                pc_next = npc;
            end
            else if (in_func_reg == FUNC_AUIPC)
            begin
                wr_req  = 1'b1;
                wr_val  = sum_pc_imm;
                pc_next = npc;
            end
            else if (in_func_reg == FUNC_ECALL)
            begin
                // pc stays on the ecall
                halt_next = STAT_ECALL;
            end
            else
            begin
                // fence, ebreak, csr forms and unused codes
                pc_next = npc;
            end
        end

        // x0 and registers past the file are never written
        wb_we  = fire && wr_req && (wr_idx != '0)
                 && ({1'b0, wr_idx} < (REG_IDX_W+1)'(NUM_REGS));
        wb_idx = wr_idx;
        wb_val = wr_val;

        if (wr_req && (wr_idx != '0) && ({1'b0, wr_idx} < (REG_IDX_W+1)'(NUM_REGS)))
        begin
            res.wb_valid = 1'b1;
            res.wb_reg   = wr_idx;
            res.wb_value = wr_val;
        end
        res.next_pc    = pc_next;
        res.run_status = halt_next;
    end

    // state update, one word per fire
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            halt_reg      <= STAT_RUN;
            pend_reg      <= 1'b0;
            pend_rd_reg   <= '0;
            pend_func_reg <= '0;
            reg_vld_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                pc_reg <= cfg_wdata;
            end
            else if (fire)
            begin
                pc_reg <= pc_next;
            end
            if (fire)
            begin
                halt_reg      <= halt_next;
                pend_reg      <= pend_next;
                pend_rd_reg   <= pend_rd_next;
                pend_func_reg <= pend_func_next;
            end
            if (wb_we)
            begin
                reg_vld_reg[wb_idx[AW-1:0]] <= 1'b1;
            end
        end
    end

    // output register
    result_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W-M_PAYLOAD_W)'(0),
                       out_reg.wb_value,
                       out_reg.wb_reg,
                       out_reg.wb_valid,
                       out_reg.mem_write_data,
                       out_reg.mem_address,
                       out_reg.mem_size,
                       out_reg.mem_write,
                       out_reg.mem_request,
                       out_reg.run_status,
                       out_reg.next_pc,
                       out_reg.retired};

endmodule

`default_nettype wire

// ===== src/rvex_ram.sv =====
`default_nettype none

module rvex_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== dv/tb_rv32i_execute_unit.sv =====
`timescale 1ns / 1ps

module tb_rv32i_execute_unit;

    import rvex_pkg::*;

    // func codes the package leaves unnamed
    localparam logic [FUNC_W-1:0] FUNC_NOP_LAST = 6'd37;   // last of fence, ebreak, csr
    localparam logic [FUNC_W-1:0] FUNC_TOP      = 6'd63;   // highest code, acts as a nop

    // retire tracker: own copy of the architectural state, builds the expected
    // result word for every accepted input word and checks the result stream
    class retire_tracker;
        logic [XLEN-1:0]      regs [32];
        logic [XLEN-1:0]      pc;
        run_status_t          status;
        bit                   pend;
        logic [REG_IDX_W-1:0] pend_rd;
        logic [FUNC_W-1:0]    pend_func;
        result_t              cur;
        result_t              queued_results [$];
        int                   errors;
        int                   effective;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc        = '0;
            status    = STAT_RUN;
            pend      = 1'b0;
            pend_rd   = '0;
            pend_func = '0;
            errors    = 0;
            effective = 0;
        endfunction

        function void set_start(logic [XLEN-1:0] addr);
            pc = addr;
        endfunction

        function int outstanding();
            return queued_results.size();
        endfunction

        function logic [XLEN-1:0] read_reg(logic [REG_IDX_W-1:0] idx);
            return (idx == '0) ? '0 : regs[idx];
        endfunction

        // x0 writes are dropped and show no write-back
        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [XLEN-1:0] v);
            if (idx != '0)
            begin
                regs[idx]    = v;
                cur.wb_valid = 1'b1;
                cur.wb_reg   = idx;
                cur.wb_value = v;
            end
        endfunction

        function logic [XLEN-1:0] alu_eval(alu_op_t op, logic [XLEN-1:0] a,
                                           logic [XLEN-1:0] b);
            case (op)
                ALU_ADD:  return a + b;
                ALU_SUB:  return a - b;
                ALU_SLL:  return a << b[4:0];
                ALU_SLT:  return {31'b0, $signed(a) < $signed(b)};
                ALU_SLTU: return {31'b0, a < b};
                ALU_XOR:  return a ^ b;
                ALU_SRL:  return a >> b[4:0];
                ALU_SRA:  return $signed(a) >>> b[4:0];
                ALU_OR:   return a | b;
                default:  return a & b;
            endcase
        endfunction

        function logic [XLEN-1:0] extend_load(logic [FUNC_W-1:0] f, logic [XLEN-1:0] d);
            case (f)
                FUNC_LB:  return {{24{d[7]}}, d[7:0]};
                FUNC_LH:  return {{16{d[15]}}, d[15:0]};
                FUNC_LBU: return {24'b0, d[7:0]};
                FUNC_LHU: return {16'b0, d[15:0]};
                default:  return d;
            endcase
        endfunction

        function void note_word(bit kind, logic [FUNC_W-1:0] func, logic [REG_IDX_W-1:0] rd,
                                logic [REG_IDX_W-1:0] rs1, logic [REG_IDX_W-1:0] rs2,
                                logic [XLEN-1:0] imm, logic [XLEN-1:0] rdata, bit ok);
            logic [XLEN-1:0] a;
            logic [XLEN-1:0] b;
            logic [XLEN-1:0] npc;
            alu_op_t         op;
            bit              taken;
            cur = '0;
            a   = read_reg(rs1);
            b   = read_reg(rs2);
            npc = pc + INSN_BYTES;
            if (status != STAT_RUN)
            begin
                // halted: nothing moves until reset
            end
            else if (kind == KIND_RESP)
            begin
                if (pend)
                begin
                    effective++;
                    pend = 1'b0;
                    if (!ok)
                        status = STAT_MEM_VIOL;
                    else
                    begin
                        if (pend_func >= FUNC_LB)
                            write_reg(pend_rd, extend_load(pend_func, rdata));
                        pc          = npc;
                        cur.retired = 1'b1;
                    end
                end
            end
            else if (!pend)
            begin
                effective++;
                cur.retired = 1'b1;
                if (func <= FUNC_AND)
                begin
                    write_reg(rd, alu_eval(alu_op_t'(func[3:0]), a, b));
                    pc = npc;
                end
                else if (func <= FUNC_ANDI)
                begin
                    case (func)
                        FUNC_ADDI:  op = ALU_ADD;
                        FUNC_SLTI:  op = ALU_SLT;
                        FUNC_SLTIU: op = ALU_SLTU;
                        FUNC_XORI:  op = ALU_XOR;
                        FUNC_ORI:   op = ALU_OR;
                        default:    op = ALU_AND;
                    endcase
                    write_reg(rd, alu_eval(op, a, imm));
                    pc = npc;
                end
                else if (func <= FUNC_LHU)
                begin
                    cur.retired     = 1'b0;
                    cur.mem_request = 1'b1;
                    cur.mem_write   = (func <= FUNC_SW);
                    case (func)
                        FUNC_SB, FUNC_LB, FUNC_LBU: cur.mem_size = SIZE_BYTE;
                        FUNC_SH, FUNC_LH, FUNC_LHU: cur.mem_size = SIZE_HALF;
                        default:                    cur.mem_size = SIZE_WORD;
                    endcase
                    cur.mem_address    = a + imm;
                    cur.mem_write_data = (func <= FUNC_SW) ? b : '0;
                    pend      = 1'b1;
                    pend_rd   = rd;
                    pend_func = func;
                end
                else if (func <= FUNC_BGEU)
                begin
                    case (func)
                        FUNC_BEQ:  taken = (a == b);
                        FUNC_BNE:  taken = (a != b);
                        FUNC_BLT:  taken = ($signed(a) < $signed(b));
                        FUNC_BGE:  taken = ($signed(a) >= $signed(b));
                        FUNC_BLTU: taken = (a < b);
                        default:   taken = (a >= b);
                    endcase
                    pc = taken ? pc + imm : npc;
                end
                else if (func == FUNC_JALR)
                begin
                    write_reg(rd, npc);
                    pc = (a + imm) & ~32'd1;
                end
                else if (func == FUNC_JAL)
                begin
                    write_reg(rd, npc);
                    pc = pc + imm;
                end
                else if (func == FUNC_LUI)
                begin
                    write_reg(rd, imm);
                    pc = npc;
                end
                else if (func == FUNC_AUIPC)
                begin
                    write_reg(rd, pc + imm);
                    pc = npc;
                end
                else if (func == FUNC_ECALL)
                    status = STAT_ECALL;
                else
                    pc = npc;
            end
            cur.next_pc    = pc;
            cur.run_status = status;
            queued_results.push_back(cur);
        endfunction

        function void cmp(string field, logic [XLEN-1:0] e, logic [XLEN-1:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, field, e, a);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] w);
            result_t e;
            result_t a;
            if (queued_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none actual %h", $time, w);
                return;
            end
            e = queued_results.pop_front();
            a = result_t'(w[M_PAYLOAD_W-1:0]);
            cmp("retired", XLEN'(e.retired), XLEN'(a.retired));
            cmp("next_pc", e.next_pc, a.next_pc);
            cmp("run_status", XLEN'(e.run_status), XLEN'(a.run_status));
            cmp("mem_request", XLEN'(e.mem_request), XLEN'(a.mem_request));
            cmp("mem_write", XLEN'(e.mem_write), XLEN'(a.mem_write));
            cmp("mem_size", XLEN'(e.mem_size), XLEN'(a.mem_size));
            cmp("mem_address", e.mem_address, a.mem_address);
            cmp("mem_write_data", e.mem_write_data, a.mem_write_data);
            cmp("wb_valid", XLEN'(e.wb_valid), XLEN'(a.wb_valid));
            cmp("wb_reg", XLEN'(e.wb_reg), XLEN'(a.wb_reg));
            cmp("wb_value", e.wb_value, a.wb_value);
            cmp("pad bits", '0, XLEN'(w[M_TDATA_W-1:M_PAYLOAD_W]));
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [XLEN-1:0]      cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // func rd rs1 rs2 imm rdata ok, see dut ports
    logic [0:0]           s_tuser   = '0;   // item_kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // retired next_pc ... wb_value, see dut ports

    // calm: no idling on either side while set
    bit calm = 1'b0;

    retire_tracker sb = new();

    rv32i_execute_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side backpressure, m_tready low with a chance of about 15 in a hundred
    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= calm || ($urandom_range(99) >= 15);
    end

    // every accepted result word goes against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("rv32i_execute_unit verification failed");
        $finish;
    end

    // present one word, hold it until accepted, then let the tracker see it
    task automatic send_word(bit kind, logic [FUNC_W-1:0] func, logic [REG_IDX_W-1:0] rd,
                             logic [REG_IDX_W-1:0] rs1, logic [REG_IDX_W-1:0] rs2,
                             logic [XLEN-1:0] imm, logic [XLEN-1:0] rdata, bit ok);
        logic [S_TDATA_W-1:0] w;
        while (!calm && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        w = '0;
        w[S_FUNC_LSB  +: FUNC_W]    = func;
        w[S_RD_LSB    +: REG_IDX_W] = rd;
        w[S_RS1_LSB   +: REG_IDX_W] = rs1;
        w[S_RS2_LSB   +: REG_IDX_W] = rs2;
        w[S_IMM_LSB   +: XLEN]      = imm;
        w[S_RDATA_LSB +: XLEN]      = rdata;
        w[S_OK_BIT]                 = ok;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(kind, func, rd, rs1, rs2, imm, rdata, ok);
    endtask

    // instruction word; the response-only fields carry noise
    task automatic insn(logic [FUNC_W-1:0] func, logic [REG_IDX_W-1:0] rd,
                        logic [REG_IDX_W-1:0] rs1, logic [REG_IDX_W-1:0] rs2,
                        logic [XLEN-1:0] imm);
        send_word(KIND_INSN, func, rd, rs1, rs2, imm, $urandom, 1'($urandom_range(1)));
    endtask

    // memory response word; the instruction fields carry noise
    task automatic resp(logic [XLEN-1:0] rdata, bit ok);
        send_word(KIND_RESP, FUNC_W'($urandom_range(63)), REG_IDX_W'($urandom_range(31)),
                  REG_IDX_W'($urandom_range(31)), REG_IDX_W'($urandom_range(31)),
                  $urandom, rdata, ok);
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // start address write, also moves pc at once
    task automatic write_start(logic [XLEN-1:0] addr);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_start(addr);
    endtask

    // half the picks from a few registers so results feed later operands
    function automatic logic [REG_IDX_W-1:0] pick_reg();
        return ($urandom_range(1) == 0) ? REG_IDX_W'($urandom_range(7))
                                        : REG_IDX_W'($urandom_range(31));
    endfunction

    function automatic logic [XLEN-1:0] pick_imm();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return $urandom_range(32) - 16;
        else if (r < 50)
        begin
            case ($urandom_range(6))
                0:       return 32'h0000_0000;
                1:       return 32'h0000_0001;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h7FFF_FFFF;
                4:       return 32'h8000_0000;
                5:       return 32'd31;
                default: return 32'd32;
            endcase
        end
        return $urandom;
    endfunction

    // load data, a quarter of it near the sign bits of byte and half
    function automatic logic [XLEN-1:0] pick_data();
        if ($urandom_range(3) != 0)
            return $urandom;
        case ($urandom_range(5))
            0:       return 32'h0000_0080;
            1:       return 32'h0000_007F;
            2:       return 32'h0000_8000;
            3:       return 32'h0000_7FFF;
            4:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // random instruction of any kind but ecall, which would halt the run
    task automatic rand_insn();
        logic [FUNC_W-1:0] f;
        logic [XLEN-1:0]   imm;
        int                r;
        r = $urandom_range(99);
        if (r < 30)
            f = FUNC_W'($urandom_range(FUNC_ADD, FUNC_AND));
        else if (r < 45)
            f = FUNC_W'($urandom_range(FUNC_ADDI, FUNC_ANDI));
        else if (r < 52)
            f = FUNC_LUI;
        else if (r < 70)
            f = FUNC_W'($urandom_range(FUNC_SB, FUNC_LHU));
        else if (r < 82)
            f = FUNC_W'($urandom_range(FUNC_BEQ, FUNC_BGEU));
        else if (r < 90)
            f = FUNC_W'($urandom_range(FUNC_JALR, FUNC_AUIPC));
        else if (r < 95)
            f = FUNC_W'($urandom_range(FUNC_ECALL + 1, FUNC_NOP_LAST));
        else
            f = FUNC_W'($urandom_range(FUNC_NOP_LAST + 1, FUNC_TOP));
        // branches and jal mostly get short word offsets
        if ((f >= FUNC_BEQ && f <= FUNC_BGEU || f == FUNC_JAL) && $urandom_range(9) != 0)
            imm = ($urandom_range(63) - 32) * 4;
        else
            imm = pick_imm();
        insn(f, pick_reg(), pick_reg(), pick_reg(), imm);
    endtask

    // mostly well formed: an access is answered right away, with some
    // instructions thrown at a pending access and stray responses in between
    task automatic run_random(int count);
        int goal;
        goal = sb.effective + count;
        while (sb.effective < goal)
        begin
            if (sb.pend)
            begin
                if ($urandom_range(99) < 90)
                    resp(pick_data(), 1'b1);
                else
                    rand_insn();
            end
            else if ($urandom_range(99) < 5)
                resp(pick_data(), 1'($urandom_range(1)));
            else
                rand_insn();
        end
    endtask

    task automatic directed();
        logic [FUNC_W-1:0] f;
        // operands at the extremes: x1 min, x2 all ones, x3 max
        insn(FUNC_LUI, 5'd1, 5'd0, 5'd0, 32'h8000_0000);
        insn(FUNC_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF);
        insn(FUNC_ADDI, 5'd3, 5'd0, 5'd0, 32'h7FFF_FFFF);
        // every register-register op, shifts by 31
        for (f = FUNC_ADD; f <= FUNC_AND; f++)
            insn(f, 5'd4 + f[4:0], 5'd1, 5'd2, 32'h0);
        insn(FUNC_SLTI, 5'd14, 5'd1, 5'd0, 32'h7FFF_FFFF);
        insn(FUNC_SLTIU, 5'd15, 5'd1, 5'd0, 32'hFFFF_FFFF);
        // write to x0 is dropped
        insn(FUNC_ADD, 5'd0, 5'd2, 5'd2, 32'h0);
        // store: base rs1, data rs2
        insn(FUNC_SW, 5'd0, 5'd1, 5'd3, 32'h0000_0010);
        resp($urandom, 1'b1);
        // signed byte load, with an instruction ignored while it waits
        insn(FUNC_LB, 5'd16, 5'd0, 5'd0, 32'h0000_0004);
        insn(FUNC_ADD, 5'd17, 5'd2, 5'd2, 32'h0);
        resp(32'hFFFF_FF80, 1'b1);
        insn(FUNC_LHU, 5'd17, 5'd3, 5'd0, 32'hFFFF_FFFF);
        resp(32'h0000_8001, 1'b1);
        // response with nothing pending, refused flag ignored too
        resp(32'h0, 1'b0);
        insn(FUNC_BLT, 5'd0, 5'd1, 5'd3, 32'hFFFF_FFF8);
        // jalr target comes out odd, bit 0 cleared
        insn(FUNC_JALR, 5'd18, 5'd2, 5'd0, 32'h0);
        insn(FUNC_JAL, 5'd19, 5'd0, 5'd0, 32'h0000_0100);
        insn(FUNC_AUIPC, 5'd20, 5'd0, 5'd0, 32'h1234_5000);
        insn(FUNC_NOP_LAST, 5'd21, 5'd1, 5'd2, 32'h0);
        insn(FUNC_TOP, 5'd22, 5'd1, 5'd2, 32'h0);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        write_start(32'h0000_1000);
        directed();

        // pc near the top so it wraps
        drain();
        write_start(32'hFFFF_FFFF);
        run_random(500);

        // back to back, no idling on either side
        drain();
        write_start(32'h0000_0000);
        calm = 1'b1;
        run_random(400);

        drain();
        calm = 1'b0;
        write_start($urandom);
        run_random(650);

        // halting can happen only once per run: ecall or a refused access,
        // then the block must ignore everything
        drain();
        if ($urandom_range(1) == 0)
            insn(FUNC_ECALL, pick_reg(), pick_reg(), pick_reg(), $urandom);
        else
        begin
            insn(FUNC_LW, 5'd5, 5'd1, 5'd0, $urandom);
            resp($urandom, 1'b0);
        end
        insn(FUNC_ADDI, 5'd6, 5'd2, 5'd0, 32'h0000_0001);
        insn(FUNC_SW, 5'd0, 5'd1, 5'd2, 32'h0);
        resp($urandom, 1'b1);
        insn(FUNC_JAL, 5'd7, 5'd0, 5'd0, 32'h0000_0040);
        drain();
        repeat (10) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("rv32i_execute_unit verification clean");
        else
            $display("rv32i_execute_unit verification failed");
        $finish;
    end

endmodule
